### rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// Five-point stencil package
// Shared types and constants of the stencil average block: register codes,
// the command control word and the back-end sequencer states.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS = 2'd1;

    // Grid size after reset.
    localparam int GRID_ROWS_RST = 32;
    localparam int GRID_COLS_RST = 32;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Divisor of the five-point average.
    localparam int DIVISOR = 5;

    // One of the three rotating line banks.
    typedef logic [1:0] t_bank;

    typedef struct packed {
        logic  do_norm;   // one result for the row above this item
        logic  do_flush;  // the item ends the grid; emit the whole last row
        t_bank cur_bank;  // bank that receives this item
        t_bank mid_bank;  // bank holding the row above
        t_bank up_norm;   // upper neighbor bank for the row above
        t_bank up_flush;  // upper neighbor bank for the final row
    } t_ctl;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD_SIDE,
        B_RD_MID,
        B_SUM,
        B_DIV,
        B_OUT
    } t_bstate;

endpackage

### rtl/stc_if.sv
// ----------------------------------------------------------------------------
// Five-point stencil channel interfaces
// Valid/ready channels for input cells, averaged results and register writes.
// ----------------------------------------------------------------------------
interface stc_cell_if #(parameter int VALUE_BITS = 24);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface stc_res_if #(
    parameter int ROW_BITS   = 10,
    parameter int COL_BITS   = 5,
    parameter int VALUE_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic [ROW_BITS-1:0]   out_row;
    logic [COL_BITS-1:0]   out_col;
    logic [VALUE_BITS-1:0] avg_value;
    logic                  run_last;

    modport source (output valid, output out_row, output out_col, output avg_value,
                    output run_last, input ready);
    modport sink   (input valid, input out_row, input out_col, input avg_value,
                    input run_last, output ready);
endinterface

interface stc_cfg_if import stc_pkg::*; #(parameter int DATA_BITS = 11);
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/five_point_stencil_average.sv
// Flow: an accepted cell passes through the command queue to the back end; each result
// takes two line reads, a sum, a multiply and an output step to reach the output register.
// The single result datapath of the back end, one result at a time, limits the flow:
// it takes no new command until it is idle again, and the last cell of a grid also
// makes it emit the whole last row.
// Reset: synchronous, active low; counters clear, grid is 32 x 32, line RAM keeps data.
// ----------------------------------------------------------------------------
// Five-point stencil average
// Raster-order cross-stencil average with replicated edges, one row behind.
// ----------------------------------------------------------------------------
module five_point_stencil_average import stc_pkg::*; #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stc_cell_if.sink  i_cell,
    stc_cfg_if.sink   i_cfg,
    stc_res_if.source o_res
);

    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CCNTW    = $clog2(MAX_COLS + 1);
    localparam int CMD_BITS = VALUE_BITS + RW + CW + CCNTW + $bits(t_ctl);

    logic                w_push_valid;
    logic                w_push_ready;
    logic [CMD_BITS-1:0] w_push_data;
    logic                w_pop_valid;
    logic                w_pop_ready;
    logic [CMD_BITS-1:0] w_pop_data;
    logic                w_back_busy;

    stc_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .CMD_BITS   (CMD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (i_cell),
        .i_cfg       (i_cfg),
        .o_cmd_valid (w_push_valid),
        .i_cmd_ready (w_push_ready),
        .o_cmd_data  (w_push_data)
    );

    stc_queue #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_push_valid),
        .o_in_ready  (w_push_ready),
        .i_in_data   (w_push_data),
        .o_out_valid (w_pop_valid),
        .i_out_ready (w_pop_ready),
        .o_out_data  (w_pop_data)
    );

    stc_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .CMD_BITS   (CMD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .o_cmd_ready (w_pop_ready),
        .i_cmd_data  (w_pop_data),
        .o_res       (o_res),
        .o_busy      (w_back_busy)
    );

`ifndef SYNTHESIS
    // Every accepted cell must land in the command queue in the same cycle.
    a_cell_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cell.valid && i_cell.ready) |-> (w_push_valid && w_push_ready))
        else $error("accepted item was not queued");

    // A new result only appears after the back end worked on a command.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_back_busy))
        else $error("result appeared without back-end activity");

    // Reset empties both the queue and the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_res.valid && !w_pop_valid))
        else $error("queue or output not empty after reset");
`endif

endmodule

### rtl/stc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module stc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/stc_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module stc_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_out_data
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_in_ready  = (r_cnt != CNTW'(DEPTH));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_mem[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_in_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

### rtl/stc_front.sv
// ----------------------------------------------------------------------------
// Stencil front end
// Holds the grid size registers and raster counters, rotates the line banks
// and turns each accepted cell into a command for the back end.
// ----------------------------------------------------------------------------
module stc_front import stc_pkg::*; #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 24,
    parameter int CMD_BITS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    stc_cell_if.sink            i_cell,
    stc_cfg_if.sink             i_cfg,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output logic [CMD_BITS-1:0] o_cmd_data
);

    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCNTW    = $clog2(MAX_ROWS + 1);
    localparam int CCNTW    = $clog2(MAX_COLS + 1);
    localparam int ROWS_RST = (GRID_ROWS_RST > MAX_ROWS) ? MAX_ROWS : GRID_ROWS_RST;
    localparam int COLS_RST = (GRID_COLS_RST > MAX_COLS) ? MAX_COLS : GRID_COLS_RST;

    logic [RCNTW-1:0] r_rows;
    logic [CCNTW-1:0] r_cols;
    logic [RW-1:0]    r_row_cnt;
    logic [CW-1:0]    r_col_cnt;
    t_bank            r_cur;
    t_bank            r_prev;
    t_bank            r_old;

    logic [RW-1:0]    w_r;
    logic [CW-1:0]    w_c;
    logic             w_row_end;
    logic             w_last;
    logic             w_fire;
    logic             w_cfg_fire;
    logic [RCNTW-1:0] w_cfg_rows;
    logic [CCNTW-1:0] w_cfg_cols;
    logic [RCNTW-1:0] w_new_rows;
    logic [CCNTW-1:0] w_new_cols;
    t_ctl             w_ctl;

    assign i_cell.ready = i_cmd_ready;
    assign i_cfg.ready  = 1'b1;
    assign o_cmd_valid  = i_cell.valid;
    assign w_fire       = i_cell.valid && i_cmd_ready;
    assign w_cfg_fire   = i_cfg.valid;

    // Low bits set the count; zero means one, above the maximum saturates.
    always_comb begin
        w_cfg_rows = i_cfg.data[RCNTW-1:0];
        w_cfg_cols = i_cfg.data[CCNTW-1:0];
        if (w_cfg_rows == '0) begin
            w_new_rows = RCNTW'(1);
        end else if (w_cfg_rows > RCNTW'(MAX_ROWS)) begin
            w_new_rows = RCNTW'(MAX_ROWS);
        end else begin
            w_new_rows = w_cfg_rows;
        end
        if (w_cfg_cols == '0) begin
            w_new_cols = CCNTW'(1);
        end else if (w_cfg_cols > CCNTW'(MAX_COLS)) begin
            w_new_cols = CCNTW'(MAX_COLS);
        end else begin
            w_new_cols = w_cfg_cols;
        end
    end

    always_comb begin
        w_r = (RCNTW'(r_row_cnt) >= r_rows) ? '0 : r_row_cnt;
        w_c = (CCNTW'(r_col_cnt) >= r_cols) ? '0 : r_col_cnt;
        w_row_end = (CCNTW'(w_c) + CCNTW'(1)) >= r_cols;
        w_last    = w_row_end && ((RCNTW'(w_r) + RCNTW'(1)) >= r_rows);

        w_ctl.do_norm  = (w_r != '0);
        w_ctl.do_flush = w_last;
        w_ctl.cur_bank = r_cur;
        w_ctl.mid_bank = r_prev;
        // The top row has no row above: its own cells stand in.
        w_ctl.up_norm  = (w_r == RW'(1)) ? r_prev : r_old;
        w_ctl.up_flush = (w_r == '0) ? r_cur : r_prev;
    end

    assign o_cmd_data = {i_cell.cell_value, w_r, w_c, r_cols, w_ctl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= RCNTW'(ROWS_RST);
            r_cols    <= CCNTW'(COLS_RST);
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_cur     <= 2'd0;
            r_prev    <= 2'd1;
            r_old     <= 2'd2;
        end else if (w_cfg_fire) begin
            if (i_cfg.index == REG_GRID_ROWS) begin
                r_rows <= w_new_rows;
            end
            if (i_cfg.index == REG_GRID_COLS) begin
                r_cols <= w_new_cols;
            end
            if (i_cfg.index == REG_GRID_ROWS || i_cfg.index == REG_GRID_COLS) begin
                r_row_cnt <= '0;
                r_col_cnt <= '0;
            end
        end else if (w_fire) begin
            if (w_row_end) begin
                r_col_cnt <= '0;
                if (w_last) begin
                    r_row_cnt <= '0;
                end else begin
                    // Rows shift down one bank; the oldest bank is reused.
                    r_row_cnt <= w_r + RW'(1);
                    r_old     <= r_prev;
                    r_prev    <= r_cur;
                    r_cur     <= r_old;
                end
            end else begin
                r_row_cnt <= w_r;
                r_col_cnt <= w_c + CW'(1);
            end
        end
    end

endmodule

### rtl/stc_back.sv
// ----------------------------------------------------------------------------
// Stencil back end
// Stores cells in the line RAM, gathers the five stencil taps, divides the sum
// by five with rounding and hands results to the output register.
// ----------------------------------------------------------------------------
module stc_back import stc_pkg::*; #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 24,
    parameter int CMD_BITS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  logic [CMD_BITS-1:0] i_cmd_data,
    stc_res_if.source           o_res,
    output logic                o_busy
);

    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CCNTW    = $clog2(MAX_COLS + 1);
    localparam int CTL_BITS = $bits(t_ctl);
    localparam int AW       = CW + 2;
    localparam int RAM_DEPTH = 3 * (1 << CW);
    localparam int SW       = VALUE_BITS + 3;
    localparam int MW       = VALUE_BITS + 2;
    localparam int MRW      = MW + 1;
    localparam int QSH      = MW + 3;
    localparam longint unsigned RECIP =
        ((64'd1 << QSH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [MRW-1:0] DIV_RECIP = MRW'(RECIP);

    // Incoming command fields.
    t_ctl                  w_in_ctl;
    logic [CCNTW-1:0]      w_in_cols;
    logic [CW-1:0]         w_in_col;
    logic [RW-1:0]         w_in_row;
    logic [VALUE_BITS-1:0] w_in_val;

    t_bstate               r_state;
    t_bstate               n_state;
    t_ctl                  r_ctl;
    logic [CCNTW-1:0]      r_cols;
    logic [RW-1:0]         r_row;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_fl;
    logic [CW-1:0]         r_k;
    logic [SW-1:0]         r_side;
    logic                  r_neg;
    logic [MW-1:0]         r_mag;
    logic [VALUE_BITS-1:0] r_q;

    logic                  r_o_valid;
    logic [RW-1:0]         r_o_row;
    logic [CW-1:0]         r_o_col;
    logic [VALUE_BITS-1:0] r_o_avg;
    logic                  r_o_last;

    t_bank                 w_mid;
    t_bank                 w_up;
    logic [CW-1:0]         w_cl;
    logic [CW-1:0]         w_cr;
    logic                  w_k_last;
    logic                  w_ram_we;
    logic [AW-1:0]         w_raddr_a;
    logic [AW-1:0]         w_raddr_b;
    logic [VALUE_BITS-1:0] w_rd_a;
    logic [VALUE_BITS-1:0] w_rd_b;
    logic                  w_load;
    logic [VALUE_BITS-1:0] w_down;
    logic [SW-1:0]         w_sum;
    logic [SW-1:0]         w_mag_full;
    logic [MW+MRW-1:0]     w_prod;
    logic [VALUE_BITS-1:0] w_q;
    logic [VALUE_BITS-1:0] w_avg;

    function automatic logic [SW-1:0] sx(input logic [VALUE_BITS-1:0] v);
        return {{3{v[VALUE_BITS-1]}}, v};
    endfunction

    assign w_in_ctl  = t_ctl'(i_cmd_data[CTL_BITS-1:0]);
    assign w_in_cols = i_cmd_data[CTL_BITS +: CCNTW];
    assign w_in_col  = i_cmd_data[CTL_BITS + CCNTW +: CW];
    assign w_in_row  = i_cmd_data[CTL_BITS + CCNTW + CW +: RW];
    assign w_in_val  = i_cmd_data[CTL_BITS + CCNTW + CW + RW +: VALUE_BITS];

    // In the final-row pass the current bank is both the middle and lower row.
    always_comb begin
        w_mid    = r_fl ? r_ctl.cur_bank : r_ctl.mid_bank;
        w_up     = r_fl ? r_ctl.up_flush : r_ctl.up_norm;
        w_cl     = (r_k == '0) ? r_k : r_k - CW'(1);
        w_k_last = (CCNTW'(r_k) + CCNTW'(1)) >= r_cols;
        w_cr     = w_k_last ? r_k : r_k + CW'(1);
    end

    stc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_waddr   ({w_in_ctl.cur_bank, w_in_col}),
        .i_wdata   (w_in_val),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && (w_in_ctl.do_norm || w_in_ctl.do_flush)) begin
                    n_state = B_RD_SIDE;
                end
            end
            B_RD_SIDE: n_state = B_RD_MID;
            B_RD_MID:  n_state = B_SUM;
            B_SUM:     n_state = B_DIV;
            B_DIV:     n_state = B_OUT;
            B_OUT: begin
                if (w_load) begin
                    if ((!r_fl && r_ctl.do_flush) || (r_fl && !w_k_last)) begin
                        n_state = B_RD_SIDE;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_cmd_ready = (r_state == B_IDLE);
        w_ram_we    = i_cmd_valid && (r_state == B_IDLE);
        w_load      = (r_state == B_OUT) && (!r_o_valid || o_res.ready);
        if (r_state == B_RD_MID) begin
            w_raddr_a = {w_mid, r_k};
            w_raddr_b = {w_up, r_k};
        end else begin
            w_raddr_a = {w_mid, w_cl};
            w_raddr_b = {w_mid, w_cr};
        end
    end

    assign o_busy = (r_state != B_IDLE);

    // Sum of the taps, then |sum| + 2 so that truncating division rounds
    // halves away from zero.
    always_comb begin
        w_down     = r_fl ? w_rd_a : r_val;
        w_sum      = r_side + sx(w_rd_a) + sx(w_rd_b) + sx(w_down);
        w_mag_full = w_sum[SW-1] ? (~w_sum + SW'(3)) : (w_sum + SW'(2));
    end

    // Division by five as a multiply by the rounded-up reciprocal; the error
    // stays below one unit for every magnitude the sum can reach.
    assign w_prod = {{MRW{1'b0}}, r_mag} * {{MW{1'b0}}, DIV_RECIP};

    assign w_q   = r_q;
    assign w_avg = r_neg ? (VALUE_BITS'(0) - w_q) : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end

        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    r_ctl  <= w_in_ctl;
                    r_cols <= w_in_cols;
                    r_row  <= w_in_row;
                    r_val  <= w_in_val;
                    r_fl   <= !w_in_ctl.do_norm;
                    r_k    <= w_in_ctl.do_norm ? w_in_col : '0;
                end
            end
            B_RD_MID: begin
                r_side <= sx(w_rd_a) + sx(w_rd_b);
            end
            B_SUM: begin
                r_neg <= w_sum[SW-1];
                r_mag <= w_mag_full[MW-1:0];
            end
            B_DIV: begin
                r_q <= w_prod[QSH +: VALUE_BITS];
            end
            B_OUT: begin
                if (w_load) begin
                    if (!r_fl) begin
                        r_fl <= 1'b1;
                        r_k  <= '0;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_load) begin
            r_o_row  <= r_fl ? r_row : r_row - RW'(1);
            r_o_col  <= r_k;
            r_o_avg  <= w_avg;
            r_o_last <= r_fl ? w_k_last : !r_ctl.do_flush;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.out_row   = r_o_row;
    assign o_res.out_col   = r_o_col;
    assign o_res.avg_value = r_o_avg;
    assign o_res.run_last  = r_o_last;

endmodule
